// ----- rtl/icnco_pkg.sv -----
// package for the interpolated cosine nco
// field widths, crossing codes and default sizes shared by the nco modules
`default_nettype none

package icnco_pkg;

  // fixed field widths of the stream and config payloads
  localparam int FIELD_W  = 27;
  localparam int SAMPLE_W = 16;
  localparam int CROSS_W  = 2;

  // default sizes
  localparam int TABLE_SIZE_DEF  = 1024;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int SAMPLE_BITS_DEF = 16;

  // crossing codes on the result stream
  localparam logic [CROSS_W-1:0] CROSS_NONE = 2'd0;
  localparam logic [CROSS_W-1:0] CROSS_WRAP = 2'd1;
  localparam logic [CROSS_W-1:0] CROSS_HALF = 2'd2;

endpackage

`default_nettype wire

// ----- rtl/icnco_ram.sv -----
// generic ram, one write port and two registered read ports
// no dependencies
`default_nettype none

module icnco_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1025
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr0_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr1_i,
  output logic      [WIDTH-1:0]         rdata0_o,
  output logic      [WIDTH-1:0]         rdata1_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata0_o <= mem_q[raddr0_i];
      rdata1_o <= mem_q[raddr1_i];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/icnco_table.sv -----
// cosine table: ram of TABLE_SIZE+1 entries loaded by a sweep after reset
// depends on icnco_pkg and icnco_ram
`default_nettype none

module icnco_table
  import icnco_pkg::*;
#(
  parameter int TABLE_SIZE  = TABLE_SIZE_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              rd_en_i,
  input  wire logic [$clog2(TABLE_SIZE+1)-1:0]   rd_addr0_i,
  input  wire logic [$clog2(TABLE_SIZE+1)-1:0]   rd_addr1_i,
  output logic      [SAMPLE_BITS-1:0]            rd_data0_o,
  output logic      [SAMPLE_BITS-1:0]            rd_data1_o,
  output logic                                   ready_o
);

  localparam int ADDR_W = $clog2(TABLE_SIZE+1);

  localparam longint unsigned TwoPiQ30  = 64'd6746518852;
  localparam longint unsigned PiQ30     = 64'd3373259426;
  localparam longint unsigned HalfPiQ30 = 64'd1686629713;
  localparam longint unsigned TaylorDiv [12] =
    '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132,
      64'd182, 64'd240, 64'd306, 64'd380, 64'd462, 64'd552};

  // q30 taylor series of the folded angle, evaluated at elaboration
  function automatic logic [SAMPLE_BITS-1:0] cos_entry(input longint unsigned k_in);
    longint unsigned k;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned v;
    longint          sum;
    longint          maxv;
    logic            neg;
    int              j;
    k    = k_in;
    neg  = 1'b0;
    maxv = (longint'(1) <<< (SAMPLE_BITS-1)) - 1;
    if (2 * k > longint'(TABLE_SIZE)) k = longint'(TABLE_SIZE) - k;
    x = TwoPiQ30 * k / TABLE_SIZE;
    if (x > HalfPiQ30) begin
      x   = PiQ30 - x;
      neg = 1'b1;
    end
    x2   = (x * x) >> 30;
    term = 64'd1 << 30;
    sum  = longint'(term);
    for (j = 1; j <= 12; j++) begin
      term = (term * x2) >> 30;
      term = term / TaylorDiv[j-1];
      if (j[0]) sum = sum - longint'(term);
      else      sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    v = (longint'(sum) + (64'd1 << (30 - SAMPLE_BITS))) >> (31 - SAMPLE_BITS);
    if (neg) return SAMPLE_BITS'(-longint'(v));
    if (longint'(v) > maxv) v = longint'(maxv);
    return SAMPLE_BITS'(v);
  endfunction

  logic [SAMPLE_BITS-1:0] init_tab [TABLE_SIZE+1];

  for (genvar g = 0; g <= TABLE_SIZE; g++) begin : g_init
    localparam logic [SAMPLE_BITS-1:0] Entry = cos_entry(longint'(g));
    assign init_tab[g] = Entry;
  end

  // load sweep, one entry a cycle
  logic                   busy_q;
  logic [ADDR_W-1:0]      cnt_q;
  logic                   wr_en_q;
  logic [ADDR_W-1:0]      wr_addr_q;
  logic [SAMPLE_BITS-1:0] wr_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b1;
      cnt_q   <= '0;
      wr_en_q <= 1'b0;
    end else begin
      wr_en_q <= busy_q;
      if (busy_q) begin
        if (cnt_q == ADDR_W'(TABLE_SIZE)) begin
          busy_q <= 1'b0;
        end else begin
          cnt_q <= cnt_q + ADDR_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    wr_addr_q <= cnt_q;
    wr_data_q <= init_tab[cnt_q];
  end

  assign ready_o = !busy_q && !wr_en_q;

  icnco_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (TABLE_SIZE+1)
  ) u_ram (
    .clk_i    (clk_i),
    .we_i     (wr_en_q),
    .waddr_i  (wr_addr_q),
    .wdata_i  (wr_data_q),
    .re_i     (rd_en_i),
    .raddr0_i (rd_addr0_i),
    .raddr1_i (rd_addr1_i),
    .rdata0_o (rd_data0_o),
    .rdata1_o (rd_data1_o)
  );

endmodule

`default_nettype wire

// ----- rtl/interpolated_cosine_nco.sv -----
// interpolated cosine nco: phase accumulator, cosine table lookup, linear interpolation
// depends on icnco_pkg and icnco_table
`default_nettype none

// One sample request per tick goes in, one cosine sample comes out per request, at a
// sustained rate of one per clock while m_axis_tready stays high. A request passes five
// registers (input, phase, table read, product, output); the two table reads share one
// dual-read ram and the interpolation uses one multiplier. After reset the table is
// loaded by a sweep, during which s_axis_tready stays low; the rate register can be
// written at any time the block is idle.
module interpolated_cosine_nco
  import icnco_pkg::*;
#(
  parameter int TABLE_SIZE  = TABLE_SIZE_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [FIELD_W-1:0]  cfg_wdata_i,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [31:0]         s_axis_tdata,   // [26:0] fm_offset
  input  wire logic                s_axis_tuser,   // [0] restart
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic      [SAMPLE_W-1:0] m_axis_tdata,   // [15:0] sample
  output logic      [CROSS_W-1:0]  m_axis_tuser    // [1:0] crossing
);

  localparam int PH_W    = $clog2(TABLE_SIZE) + FRAC_BITS;
  localparam int SUM_W   = PH_W + 2;
  localparam int CMP_W   = ((FIELD_W > PH_W + 2) ? FIELD_W : PH_W + 2) + 1;
  localparam int ADDR_W  = $clog2(TABLE_SIZE+1);
  localparam int PROD_W  = FRAC_BITS + SAMPLE_BITS + 2;
  localparam int RES_W   = PROD_W + SAMPLE_W;

  localparam longint ModVal  = longint'(TABLE_SIZE) <<< FRAC_BITS;
  localparam longint HalfVal = ModVal / 2;

  localparam logic signed [CMP_W-1:0] HalfC  = CMP_W'(HalfVal);
  localparam logic signed [SUM_W-1:0] ModS   = SUM_W'(ModVal);
  localparam logic signed [SUM_W-1:0] HalfS  = SUM_W'(HalfVal);
  localparam logic        [PH_W-1:0]  HalfP  = PH_W'(HalfVal);
  localparam logic        [PH_W:0]    ModP   = (PH_W+1)'(ModVal);
  localparam logic signed [PROD_W-1:0] RoundC = PROD_W'(longint'(1) <<< (FRAC_BITS-1));

  function automatic logic signed [CMP_W-1:0] clamp_half(input logic signed [CMP_W-1:0] v);
    if (v > HalfC)  return HalfC;
    if (v < -HalfC) return -HalfC;
    return v;
  endfunction

  // rate register
  logic signed [FIELD_W-1:0] rate_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= FIELD_W'(longint'(1) <<< FRAC_BITS);
    end else if (cfg_we_i) begin
      rate_q <= cfg_wdata_i;
    end
  end

  // pipeline control
  logic a_valid_q, b_valid_q, c_valid_q, d_valid_q, out_valid_q;
  logic load_a, load_b, load_c, load_d, load_e;
  logic table_ready;
  logic s_accept;

  assign load_e   = !out_valid_q || m_axis_tready;
  assign load_d   = !d_valid_q || load_e;
  assign load_c   = !c_valid_q || load_d;
  assign load_b   = !b_valid_q || load_c;
  assign load_a   = !a_valid_q || load_b;
  assign s_axis_tready = load_a && table_ready;
  assign s_accept = s_axis_tvalid && s_axis_tready;

  // stage a: input register
  logic [FIELD_W-1:0] a_fm_q;
  logic               a_restart_q;

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      a_fm_q      <= s_axis_tdata[FIELD_W-1:0];
      a_restart_q <= s_axis_tuser;
    end
  end

  // phase step and wrap, half crossing and restart
  logic [PH_W-1:0]    phase_q, phase_d;
  logic [CROSS_W-1:0] b_cross_q, cross_d;

  always_comb begin
    logic signed [CMP_W-1:0] rate_cl;
    logic signed [CMP_W-1:0] fm_cl;
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] sum_dn;
    logic signed [SUM_W-1:0] sum_up;
    rate_cl = clamp_half(CMP_W'(rate_q));
    fm_cl   = clamp_half(CMP_W'($signed(a_fm_q)));
    sum     = $signed({2'b00, phase_q}) + rate_cl[SUM_W-1:0] + fm_cl[SUM_W-1:0];
    sum_dn  = sum - ModS;
    sum_up  = sum + ModS;
    if (a_restart_q) begin
      phase_d = '0;
      cross_d = CROSS_WRAP;
    end else if (sum >= ModS) begin
      phase_d = sum_dn[PH_W-1:0];
      cross_d = CROSS_WRAP;
    end else if (sum >= HalfS && phase_q < HalfP) begin
      phase_d = sum[PH_W-1:0];
      cross_d = CROSS_HALF;
    end else if (sum[SUM_W-1]) begin
      phase_d = sum_up[PH_W-1:0];
      cross_d = CROSS_WRAP;
    end else begin
      phase_d = sum[PH_W-1:0];
      cross_d = CROSS_NONE;
    end
  end

  // stage b: phase state, drives the table addresses
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else if (load_b && a_valid_q) begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_b && a_valid_q) begin
      b_cross_q <= cross_d;
    end
  end

  logic [ADDR_W-1:0]      rd_addr0, rd_addr1;
  logic [SAMPLE_BITS-1:0] rd_a, rd_b;

  assign rd_addr0 = ADDR_W'(phase_q[PH_W-1:FRAC_BITS]);
  assign rd_addr1 = rd_addr0 + ADDR_W'(1);

  icnco_table #(
    .TABLE_SIZE  (TABLE_SIZE),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (load_c),
    .rd_addr0_i (rd_addr0),
    .rd_addr1_i (rd_addr1),
    .rd_data0_o (rd_a),
    .rd_data1_o (rd_b),
    .ready_o    (table_ready)
  );

  // stage c: table data, mix and crossing
  logic [FRAC_BITS-1:0] c_mix_q;
  logic [CROSS_W-1:0]   c_cross_q;

  always_ff @(posedge clk_i) begin
    if (load_c) begin
      c_mix_q   <= phase_q[FRAC_BITS-1:0];
      c_cross_q <= b_cross_q;
    end
  end

  logic signed [SAMPLE_BITS:0]  diff;
  logic signed [PROD_W-1:0]     prod_d;

  assign diff   = (SAMPLE_BITS+1)'($signed(rd_b)) - (SAMPLE_BITS+1)'($signed(rd_a));
  assign prod_d = PROD_W'($signed({1'b0, c_mix_q})) * PROD_W'(diff);

  // stage d: product
  logic signed [PROD_W-1:0]      d_prod_q;
  logic signed [SAMPLE_BITS-1:0] d_a_q;
  logic        [CROSS_W-1:0]     d_cross_q;

  always_ff @(posedge clk_i) begin
    if (load_d) begin
      d_prod_q  <= prod_d;
      d_a_q     <= $signed(rd_a);
      d_cross_q <= c_cross_q;
    end
  end

  // round to nearest, ties up, then add base entry
  logic signed [PROD_W-1:0] t_rnd;
  logic signed [PROD_W-1:0] q_rnd;
  logic signed [RES_W-1:0]  res;

  assign t_rnd = d_prod_q + RoundC;
  assign q_rnd = t_rnd >>> FRAC_BITS;
  assign res   = RES_W'(d_a_q) + RES_W'(q_rnd);

  // stage e: output register
  logic [SAMPLE_W-1:0] out_sample_q;
  logic [CROSS_W-1:0]  out_cross_q;

  always_ff @(posedge clk_i) begin
    if (load_e && d_valid_q) begin
      out_sample_q <= res[SAMPLE_W-1:0];
      out_cross_q  <= d_cross_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      c_valid_q   <= 1'b0;
      d_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (load_a) a_valid_q   <= s_accept;
      if (load_b) b_valid_q   <= a_valid_q;
      if (load_c) c_valid_q   <= b_valid_q;
      if (load_d) d_valid_q   <= c_valid_q;
      if (load_e) out_valid_q <= d_valid_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_sample_q;
  assign m_axis_tuser  = out_cross_q;

`ifndef SYNTH
  a_phase_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, phase_q} < ModP)
    else $error("phase outside one table period");

  a_restart_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_valid_q && a_restart_q && load_b |=> phase_q == '0 && b_cross_q == CROSS_WRAP)
    else $error("restart did not clear phase");

  a_half_upper : assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_valid_q && b_cross_q == CROSS_HALF |-> phase_q >= HalfP)
    else $error("half crossing flagged below half");

  a_idle_during_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !table_ready |-> !a_valid_q && !b_valid_q && !out_valid_q)
    else $error("request in flight while table loads");
`endif

endmodule

`default_nettype wire
